FILE: rtl/cdfsel_pkg.sv
// Package for the CDF table contact selector.
// Shared field widths, request codes, register indexes and parameter defaults.
// No dependencies.
package cdfsel_pkg;

  // Field widths fixed by the interface
  localparam int ACTION_W   = 1;
  localparam int IDX_W      = 10;
  localparam int PROB_W     = 33;
  localparam int PATCH_W    = 24;
  localparam int DRAW_W     = 32;
  localparam int CNT_W      = 11;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;

  // Parameter defaults
  localparam int DEF_MAX_ENTRIES   = 1024;
  localparam int DEF_PATCH_ID_BITS = 24;

  // Request codes
  localparam logic [ACTION_W-1:0] ACTION_LOAD  = 1'b0;
  localparam logic [ACTION_W-1:0] ACTION_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_PATCH_ID   = 1'b1;

endpackage

FILE: rtl/cdf_table_contact_select.sv
// Top level of the CDF table contact selector: configuration registers,
// probability and patch RAMs, request sequencer.
// Depends on cdfsel_pkg, cdfsel_ram, cdfsel_search.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low.
//   action = load writes entry_prob / entry_patch at entry_index
//   and gives no result; busy stays low, so loads can go every cycle.
//   action = query takes draw and gives exactly one result, shown for one
//   cycle with done high on contact_patch, chosen_index, is_own_patch.
//   Empty table: result in the cycle after the request, busy stays low.
//   Otherwise the chop over the probability RAM costs one RAM read per probe.
//   A query reads the first entry, then the last entry, then runs the chop
//   unless the draw lies below the first or above the last entry, and ends
//   with the patch RAM read; busy is high from the cycle after the request
//   until the result cycle, in which the next request may already be taken.
//   The receiver cannot stall: done is a one-cycle strobe.
//   Configuration (cfg_we, cfg_index, cfg_data) is written while idle:
//   index 0 entries_in_use, index 1 own_patch_id.
//   Reset (rst, synchronous) returns to idle and clears both registers; the
//   tables are not cleared and must be loaded before they are queried.
module cdf_table_contact_select
  import cdfsel_pkg::*;
#(
  parameter int MAX_ENTRIES   = DEF_MAX_ENTRIES,
  parameter int PATCH_ID_BITS = DEF_PATCH_ID_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [ACTION_W-1:0]   action,
  input  logic [IDX_W-1:0]      entry_index,
  input  logic [PROB_W-1:0]     entry_prob,
  input  logic [PATCH_W-1:0]    entry_patch,
  input  logic [DRAW_W-1:0]     draw,
  output logic                  done,
  output logic [PATCH_W-1:0]    contact_patch,
  output logic [IDX_W-1:0]      chosen_index,
  output logic                  is_own_patch
);

  localparam int IW = $clog2(MAX_ENTRIES);

  logic [CNT_W-1:0]         entries_in_use;
  logic [PATCH_W-1:0]       own_patch_id;

  logic                     mem_we;
  logic [IW-1:0]            mem_waddr;
  logic [PROB_W-1:0]        prob_wdata;
  logic [PATCH_ID_BITS-1:0] patch_wdata;
  logic [IW-1:0]            prob_raddr;
  logic [PROB_W-1:0]        prob_rdata;
  logic [IW-1:0]            patch_raddr;
  logic [PATCH_ID_BITS-1:0] patch_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
      own_patch_id   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTRIES_IN_USE: entries_in_use <= CNT_W'(cfg_data);
        CFG_OWN_PATCH_ID:   own_patch_id   <= PATCH_W'(cfg_data);
      endcase
    end
  end

  cdfsel_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (PROB_W)
  ) u_prob_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (prob_wdata),
    .raddr (prob_raddr),
    .rdata (prob_rdata)
  );

  cdfsel_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (PATCH_ID_BITS)
  ) u_patch_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (patch_wdata),
    .raddr (patch_raddr),
    .rdata (patch_rdata)
  );

  cdfsel_search #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .PATCH_ID_BITS (PATCH_ID_BITS)
  ) u_search (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .action         (action),
    .entry_index    (entry_index),
    .entry_prob     (entry_prob),
    .entry_patch    (entry_patch),
    .draw           (draw),
    .busy           (busy),
    .entries_in_use (entries_in_use),
    .own_patch_id   (own_patch_id),
    .done           (done),
    .contact_patch  (contact_patch),
    .chosen_index   (chosen_index),
    .is_own_patch   (is_own_patch),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .prob_wdata     (prob_wdata),
    .patch_wdata    (patch_wdata),
    .prob_raddr     (prob_raddr),
    .prob_rdata     (prob_rdata),
    .patch_raddr    (patch_raddr),
    .patch_rdata    (patch_rdata)
  );

endmodule

FILE: rtl/cdfsel_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Used for the probability and patch tables. Depends on nothing.
module cdfsel_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 33,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cdfsel_search.sv
// Request sequencer for the CDF table contact selector: table loads and the
// binary chop over the probability RAM, then the patch RAM read.
// Depends on cdfsel_pkg.
module cdfsel_search
  import cdfsel_pkg::*;
#(
  parameter int MAX_ENTRIES   = DEF_MAX_ENTRIES,
  parameter int PATCH_ID_BITS = DEF_PATCH_ID_BITS,
  localparam int IW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 2)
) (
  input  logic                     clk,
  input  logic                     rst,
  // request side
  input  logic                     start,
  input  logic [ACTION_W-1:0]      action,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic [PROB_W-1:0]        entry_prob,
  input  logic [PATCH_W-1:0]       entry_patch,
  input  logic [DRAW_W-1:0]        draw,
  output logic                     busy,
  // configuration
  input  logic [CNT_W-1:0]         entries_in_use,
  input  logic [PATCH_W-1:0]       own_patch_id,
  // result side
  output logic                     done,
  output logic [PATCH_W-1:0]       contact_patch,
  output logic [IDX_W-1:0]         chosen_index,
  output logic                     is_own_patch,
  // table RAMs
  output logic                     mem_we,
  output logic [IW-1:0]            mem_waddr,
  output logic [PROB_W-1:0]        prob_wdata,
  output logic [PATCH_ID_BITS-1:0] patch_wdata,
  output logic [IW-1:0]            prob_raddr,
  input  logic [PROB_W-1:0]        prob_rdata,
  output logic [IW-1:0]            patch_raddr,
  input  logic [PATCH_ID_BITS-1:0] patch_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_PROBE,
    S_PATCH
  } state_t;

  state_t            state;
  logic [CW-1:0]     n;
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi;
  logic [CW-1:0]     probe;
  logic [CW-1:0]     k;
  logic [PROB_W-1:0] draw_q;

  logic              accept;
  logic              is_query;
  logic [CW-1:0]     n_next;
  logic [CW-1:0]     n_last;
  logic [CW-1:0]     lo_next;
  logic [CW-1:0]     hi_next;
  logic [CW-1:0]     step;
  logic [CW-1:0]     probe_sum;
  logic [CW-1:0]     probe_next;
  logic [CW-1:0]     lo_inc;
  logic [CW-1:0]     k_next;
  logic              below;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign is_query = (action == ACTION_QUERY);

  // Entry count saturates at the table depth
  always_comb begin
    if (32'(entries_in_use) >= 32'(MAX_ENTRIES)) begin
      n_next = CW'(MAX_ENTRIES);
    end else begin
      n_next = CW'(entries_in_use);
    end
  end

  assign n_last = n - 1'b1;

  // Table loads, out-of-range indexes dropped
  assign mem_we      = accept && !is_query && (32'(entry_index) < 32'(MAX_ENTRIES));
  assign mem_waddr   = IW'(entry_index);
  assign prob_wdata  = entry_prob;
  assign patch_wdata = PATCH_ID_BITS'(entry_patch);

  // One chop step: narrow the bracket, pick the next probe and the fallback index
  always_comb begin
    below   = (prob_rdata < draw_q);
    lo_next = lo;
    hi_next = hi;
    if (state == S_LAST) begin
      lo_next = '0;
      hi_next = n + 1'b1;
    end else if (below) begin
      lo_next = probe;
    end else begin
      hi_next = probe;
    end
    step      = (hi_next - lo_next) >> 1;
    probe_sum = lo_next + step;
    probe_next = (probe_sum >= n) ? n_last : probe_sum;
    lo_inc    = lo_next + 1'b1;
    k_next    = (lo_inc >= n) ? n_last : lo_inc;
  end

  // RAM read addresses
  always_comb begin
    prob_raddr  = '0;
    patch_raddr = IW'(k_next);
    unique case (state)
      S_IDLE: begin
        prob_raddr = '0;
      end
      S_FIRST: begin
        prob_raddr  = IW'(n_last);
        patch_raddr = '0;
      end
      S_LAST: begin
        prob_raddr  = IW'(probe_next);
        patch_raddr = IW'(n_last);
      end
      S_PROBE: begin
        prob_raddr  = IW'(probe_next);
        patch_raddr = IW'(k_next);
      end
      S_PATCH: begin
        prob_raddr = '0;
      end
    endcase
  end

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && is_query) begin
            draw_q <= PROB_W'(draw);
            n      <= n_next;
            if (n_next == '0) begin
              done          <= 1'b1;
              contact_patch <= own_patch_id;
              chosen_index  <= '0;
              is_own_patch  <= 1'b1;
            end else begin
              state <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          // below the first entry: index 0
          if (draw_q < prob_rdata) begin
            k     <= '0;
            state <= S_PATCH;
          end else begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          // above the last entry: index n-1, else open the chop
          if (draw_q > prob_rdata) begin
            k     <= n_last;
            state <= S_PATCH;
          end else begin
            lo    <= lo_next;
            hi    <= hi_next;
            probe <= probe_next;
            k     <= k_next;
            state <= (step == '0) ? S_PATCH : S_PROBE;
          end
        end
        S_PROBE: begin
          lo    <= lo_next;
          hi    <= hi_next;
          probe <= probe_next;
          k     <= k_next;
          if (step == '0) begin
            state <= S_PATCH;
          end
        end
        S_PATCH: begin
          done          <= 1'b1;
          contact_patch <= PATCH_W'(patch_rdata);
          chosen_index  <= IDX_W'(k);
          is_own_patch  <= 1'b0;
          state         <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/cdfsel_checker.sv
// Port-level checks for the CDF table contact selector, bound to the top level.
// Depends on cdfsel_pkg and cdf_table_contact_select.
module cdfsel_checker
  import cdfsel_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic [ACTION_W-1:0]   action,
  input logic                  done,
  input logic [IDX_W-1:0]      chosen_index,
  input logic                  is_own_patch
);

  // A load request never produces a result
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (!rst && start && !busy && action == ACTION_LOAD) |=> !done)
    else $error("result after a load request");

  // A query either answers at once or keeps the block busy
  a_query_progress: assert property (@(posedge clk) disable iff (rst)
    (!rst && start && !busy && action == ACTION_QUERY) |=> (busy || done))
    else $error("query request dropped");

  // Results only appear when the sequencer is back at idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while busy");

  // Own-patch answers carry index zero
  a_own_index: assert property (@(posedge clk) disable iff (rst)
    (done && is_own_patch) |-> (chosen_index == '0))
    else $error("own patch with nonzero index");

endmodule

bind cdf_table_contact_select cdfsel_checker u_cdfsel_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .action       (action),
  .done         (done),
  .chosen_index (chosen_index),
  .is_own_patch (is_own_patch)
);

FILE: test/tb.sv
// Self-checking testbench for cdf_table_contact_select: table loads, empty-table
// queries and binary-chop contact selection, checked against an in-bench predictor.
// Depends on cdfsel_pkg and the cdf_table_contact_select RTL.
`timescale 1ns / 100ps

module tb;
  import cdfsel_pkg::*;

  localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
  localparam int ITEM_TARGET = 1300;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 600000;
  localparam int REPORT_MAX = 10;
  localparam longint unsigned PROB_ONE = 64'h1_0000_0000;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [IDX_W-1:0]    entry_index;
    logic [PROB_W-1:0]   entry_prob;
    logic [PATCH_W-1:0]  entry_patch;
    logic [DRAW_W-1:0]   draw;
  } request_t;

  typedef struct packed {
    logic [PATCH_W-1:0] patch;
    logic [IDX_W-1:0]   index;
    logic               own;
  } contact_t;

  typedef enum logic {ROW_REGS, ROW_REQ} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    request_t           req;
    logic [CNT_W-1:0]   count;
    logic [PATCH_W-1:0] own;
    logic               known;
    contact_t           want;
  } plan_row_t;

  // DUT ports
  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ACTION_W-1:0]   action = ACTION_LOAD;
  logic [IDX_W-1:0]      entry_index = '0;
  logic [PROB_W-1:0]     entry_prob = '0;
  logic [PATCH_W-1:0]    entry_patch = '0;
  logic [DRAW_W-1:0]     draw = '0;
  logic                  done;
  logic [PATCH_W-1:0]    contact_patch;
  logic [IDX_W-1:0]      chosen_index;
  logic                  is_own_patch;

  // Predictor state: tables, registers, written map
  logic [PROB_W-1:0]  prob_mem [TABLE_DEPTH];
  logic [PATCH_W-1:0] patch_mem [TABLE_DEPTH];
  bit                 written [TABLE_DEPTH];
  logic [CNT_W-1:0]   count_reg = '0;
  logic [PATCH_W-1:0] own_reg = '0;

  contact_t  pending_contacts[$];
  plan_row_t plan[$];

  int mismatches = 0;
  int items_sent = 0;
  int loads_sent = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit steady = 1'b0;

  cdf_table_contact_select DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .entry_index  (entry_index),
    .entry_prob   (entry_prob),
    .entry_patch  (entry_patch),
    .draw         (draw),
    .done         (done),
    .contact_patch(contact_patch),
    .chosen_index (chosen_index),
    .is_own_patch (is_own_patch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expected contact for a draw against the current table and registers
  function automatic contact_t select_contact(input logic [DRAW_W-1:0] d);
    contact_t    c;
    int unsigned n, lo, hi, step, probe;
    logic [PROB_W-1:0] x;
    x = {1'b0, d};
    n = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
    if (n == 0) begin
      c.patch = own_reg;
      c.index = '0;
      c.own = 1'b1;
      return c;
    end
    lo = 0;
    if (x < prob_mem[0]) begin
      lo = 0;
    end else if (x > prob_mem[n-1]) begin
      lo = n - 1;
    end else begin
      hi = n + 1;
      step = (hi - lo) / 2;
      while (step != 0) begin
        probe = lo + step;
        if (probe >= n) probe = n - 1;
        if (prob_mem[probe] < x) lo = probe;
        else hi = probe;
        step = (hi - lo) / 2;
      end
      lo++;
    end
    if (lo >= n) lo = n - 1;
    c.patch = patch_mem[lo];
    c.index = lo[IDX_W-1:0];
    c.own = 1'b0;
    return c;
  endfunction

  // Probability in [0, 1.0] Q1.32, with 1.0 itself now and then
  function automatic logic [PROB_W-1:0] rand_prob();
    if ($urandom_range(0, 15) == 0) return PROB_ONE[PROB_W-1:0];
    return {1'b0, $urandom};
  endfunction

  // Unused fields of a request carry noise
  function automatic request_t make_load(input logic [IDX_W-1:0] idx,
                                         input logic [PROB_W-1:0] prob,
                                         input logic [PATCH_W-1:0] patch);
    request_t r;
    r.action = ACTION_LOAD;
    r.entry_index = idx;
    r.entry_prob = prob;
    r.entry_patch = patch;
    r.draw = $urandom;
    return r;
  endfunction

  function automatic request_t make_query(input logic [DRAW_W-1:0] d);
    request_t r;
    r.action = ACTION_QUERY;
    r.entry_index = IDX_W'($urandom);
    r.entry_prob = rand_prob();
    r.entry_patch = PATCH_W'($urandom);
    r.draw = d;
    return r;
  endfunction

  function automatic void add_req(input request_t r, input bit known, input contact_t want);
    plan_row_t row;
    row = '0;
    row.kind = ROW_REQ;
    row.req = r;
    row.known = known;
    row.want = want;
    plan.push_back(row);
  endfunction

  function automatic void add_regs(input logic [CNT_W-1:0] n, input logic [PATCH_W-1:0] own);
    plan_row_t row;
    row = '0;
    row.kind = ROW_REGS;
    row.count = n;
    row.own = own;
    plan.push_back(row);
  endfunction

  function automatic void flag_failure(input string msg);
    if (mismatches < REPORT_MAX) $display("MISMATCH: %s", msg);
    mismatches++;
  endfunction

  // Present one request and hold it until taken; update the predictor on acceptance
  task automatic issue(input request_t r, input bit known, input contact_t want);
    start <= 1'b1;
    action <= r.action;
    entry_index <= r.entry_index;
    entry_prob <= r.entry_prob;
    entry_patch <= r.entry_patch;
    draw <= r.draw;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (r.action == ACTION_LOAD) begin
      prob_mem[r.entry_index] = r.entry_prob;
      patch_mem[r.entry_index] = r.entry_patch;
      written[r.entry_index] = 1'b1;
      loads_sent++;
    end else begin
      pending_contacts.push_back(known ? want : select_contact(r.draw));
    end
  endtask

  // Bursts of requests separated by random gaps, unless the phase runs steady
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Stop sending until every result is back and the block has settled
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_contacts.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CNT_W-1:0] n, input logic [PATCH_W-1:0] own);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ENTRIES_IN_USE;
    cfg_data <= CFG_DATA_W'(n);
    @(posedge clk);
    cfg_index <= CFG_OWN_PATCH_ID;
    cfg_data <= own;
    @(posedge clk);
    cfg_we <= 1'b0;
    count_reg = n;
    own_reg = own;
  endtask

  // Result checker: one expectation per done strobe, in order
  always @(posedge clk) begin : check_results
    contact_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_contacts.size() == 0) begin
        flag_failure($sformatf("result with none pending: patch %h index %0d own %b",
                               contact_patch, chosen_index, is_own_patch));
      end else begin
        want = pending_contacts.pop_front();
        if (contact_patch !== want.patch || chosen_index !== want.index ||
            is_own_patch !== want.own)
          flag_failure($sformatf("expected patch %h index %0d own %b, got %h %0d %b",
                                 want.patch, want.index, want.own,
                                 contact_patch, chosen_index, is_own_patch));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    request_t          r;
    plan_row_t         row;
    int                phase, n, neff, nq, k, pick;
    bit                sorted;
    longint unsigned   acc, span, inc;
    logic [PATCH_W-1:0] own;
    logic [DRAW_W-1:0] d;

    // Directed table: reset state, empty table, one-entry and four-entry tables,
    // both ends of the draw, a draw equal to an entry, and an unsorted table
    add_req(make_query('0), 1'b1, '{patch: '0, index: '0, own: 1'b1});
    add_regs(0, 24'hFFFFFF);
    add_req(make_query(32'hFFFFFFFF), 1'b1, '{patch: 24'hFFFFFF, index: '0, own: 1'b1});
    add_req(make_load(10'd0, 33'h0_0000_0100, 24'h000001), 1'b0, '0);
    add_req(make_load(10'd1, 33'h0_4000_0000, 24'h000A5A), 1'b0, '0);
    add_req(make_load(10'd2, 33'h0_8000_0000, 24'hFFFFFF), 1'b0, '0);
    add_req(make_load(10'd3, 33'h1_0000_0000, 24'h123456), 1'b0, '0);
    add_req(make_load(10'd1023, 33'h0_FFFF_FFFF, 24'h800000), 1'b0, '0);
    add_regs(1, 0);
    add_req(make_query('0), 1'b1, '{patch: 24'h000001, index: '0, own: 1'b0});
    add_req(make_query(32'hFFFFFFFF), 1'b1, '{patch: 24'h000001, index: '0, own: 1'b0});
    add_req(make_query(32'h0000_0100), 1'b0, '0);
    add_regs(4, 24'h5A5A5A);
    add_req(make_query('0), 1'b1, '{patch: 24'h000001, index: '0, own: 1'b0});
    add_req(make_query(32'h4000_0000), 1'b0, '0);
    add_req(make_query(32'h4000_0001), 1'b0, '0);
    add_req(make_query(32'h7FFF_FFFF), 1'b0, '0);
    add_req(make_query(32'hFFFF_FFFF), 1'b0, '0);
    add_req(make_load(10'd3, 33'h0_8000_0000, 24'h123456), 1'b0, '0);
    add_req(make_query(32'hFFFF_FFFF), 1'b1, '{patch: 24'h123456, index: 10'd3, own: 1'b0});
    add_req(make_load(10'd1, 33'h0_0000_0000, 24'h00FF00), 1'b0, '0);
    add_req(make_query(32'h5000_0000), 1'b0, '0);
    add_req(make_query(32'h0000_0000), 1'b0, '0);
    add_regs(0, 24'h3C3C3C);
    add_req(make_query(32'h1234_5678), 1'b1, '{patch: 24'h3C3C3C, index: '0, own: 1'b1});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REGS) begin
        drain();
        program_regs(row.count, row.own);
      end else begin
        issue(row.req, row.known, row.want);
      end
    end

    // Random phases: program, load a table covering every index in use, then
    // queries mixed with stray loads. A few phases use the full and oversized counts.
    phase = 0;
    while (items_sent < ITEM_TARGET || phase < 10) begin
      phase++;
      drain();
      case (phase)
        4: n = TABLE_DEPTH;
        7: n = 2047;
        9: n = TABLE_DEPTH + 1;
        default: begin
          pick = $urandom_range(0, 9);
          if (pick == 0) n = 0;
          else if (pick <= 5) n = $urandom_range(1, 8);
          else if (pick <= 8) n = $urandom_range(9, 64);
          else n = $urandom_range(65, 200);
        end
      endcase
      pick = $urandom_range(0, 5);
      own = (pick == 0) ? '0 : (pick == 1) ? 24'hFFFFFF : PATCH_W'($urandom);
      program_regs(CNT_W'(n), own);
      neff = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
      steady = ($urandom_range(0, 3) == 0);
      burst_left = 0;

      // Cumulative table, mostly sorted; big tables only fill what was never written
      sorted = ($urandom_range(0, 4) != 0);
      acc = 0;
      span = (neff == 0) ? 0 : PROB_ONE / neff;
      for (int i = 0; i < neff; i++) begin
        inc = ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom) % (span * 2 + 1);
        acc = (acc + inc > PROB_ONE) ? PROB_ONE : acc + inc;
        if (i == neff - 1 && $urandom_range(0, 1) == 1) acc = PROB_ONE;
        if (neff <= 256 || !written[i]) begin
          pace();
          issue(make_load(i[IDX_W-1:0], sorted ? acc[PROB_W-1:0] : rand_prob(),
                          PATCH_W'($urandom)), 1'b0, '0);
        end
      end

      nq = $urandom_range(10, 40);
      repeat (nq) begin
        pace();
        if ($urandom_range(0, 6) == 0) begin
          issue(make_load(IDX_W'($urandom), rand_prob(), PATCH_W'($urandom)), 1'b0, '0);
        end else begin
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            d = '0;
          end else if (pick == 1) begin
            d = '1;
          end else if (pick <= 4 && neff != 0) begin
            // land on or next to a stored entry
            k = $urandom_range(0, neff - 1);
            if (prob_mem[k][PROB_W-1]) d = '1;
            else d = prob_mem[k][DRAW_W-1:0] + DRAW_W'($urandom_range(0, 2)) - 1'b1;
          end else begin
            d = $urandom;
          end
          r = make_query(d);
          issue(r, 1'b0, '0);
        end
      end
    end

    drain();
    $display("Covered %0d requests (%0d table loads) over %0d random phases,",
             items_sent, loads_sent, phase);
    $display("%0d contact results checked, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && pending_contacts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
